// ===== hw/rtl/che_pkg.sv =====
// Shared types and codes for the cuckoo hash insert engine.
`timescale 1ns / 1ps
package che_pkg;

    // function codes carried in s_tuser
    localparam logic [1:0] FUNC_INSERT     = 2'd0;
    localparam logic [1:0] FUNC_READ_BIN   = 2'd1;
    localparam logic [1:0] FUNC_READ_STASH = 2'd2;

    // result status codes carried in m_tuser
    localparam logic [1:0] STAT_PLACED  = 2'd0;
    localparam logic [1:0] STAT_STASHED = 2'd1;
    localparam logic [1:0] STAT_REJECT  = 2'd2;
    localparam logic [1:0] STAT_READ    = 2'd3;

    // configuration register indexes (byte address 4*index)
    localparam logic [1:0] REG_HASH_COUNT  = 2'd0;
    localparam logic [1:0] REG_MAX_KICKS   = 2'd1;
    localparam logic [1:0] REG_STASH_LIMIT = 2'd2;
    localparam logic [1:0] REG_DUMMY_FILL  = 2'd3;

    localparam int PADDR_W   = 4;
    localparam int IN_ADDR_W = 12;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  hash_count;
        logic [15:0] max_kicks;
        logic [2:0]  stash_limit;
        logic [7:0]  dummy_fill;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] kick_count;
        logic        occupied;
        logic [15:0] entry_id;
        logic [63:0] entry_value;
    } res_t;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_REDUCE,
        FE_PUSH
    } fe_state_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_PROBE_RD,
        BK_PROBE_CHK,
        BK_EVICT_RD,
        BK_EVICT_WR,
        BK_STASH,
        BK_BIN_RD,
        BK_BIN_CHK,
        BK_RESULT
    } bk_state_t;

endpackage

// ===== hw/rtl/cuckoo_hash_insert_engine.sv =====
// Top level of the cuckoo hash insert engine: config registers, front, back, result register.
`timescale 1ns / 1ps
// Cuckoo hash table with stash. After reset the engine runs a clearing pass over the bin
// memory with s_tready low; configuration writes are taken meanwhile.
// Items go through a front end that folds the bin addresses into the table range
// (overlapped with the engine) into a two-entry queue. The engine uses the single read
// port of the bin memory: an insert reads and checks each candidate bin in turn, then
// reads and rewrites the victim bin for each eviction round; a bin read reads, checks
// and returns the bin, and a stash read answers from the stash registers directly.
// One result per item, in order, held in an output register so the next item proceeds.
module cuckoo_hash_insert_engine
    import che_pkg::*;
#(
    parameter int NUM_BINS    = 4096,
    parameter int MAX_HASHES  = 3,
    parameter int STASH_DEPTH = 4,
    parameter int TAG_BITS    = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // element_id, addr_first, addr_second, addr_third, tag_value, read_index
    input  logic [127:0]       s_tdata,
    // func
    input  logic [1:0]         s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    // kick_count, occupied, entry_id, entry_value, zero pad
    output logic [103:0]       m_tdata,
    // status
    output logic [1:0]         m_tuser,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CW = 2 + 16 + 4 * $clog2(NUM_BINS) + IN_ADDR_W + TAG_BITS;

    cfg_t        cfg_reg;
    logic        cfg_we;
    logic [1:0]  cfg_idx;

    logic          clearing;
    logic          q_push, q_full, q_pop, q_empty;
    logic [CW-1:0] q_in, q_out;
    logic          res_valid, res_ready;
    res_t          res;
    logic          m_valid_reg;
    res_t          m_res_reg;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hash_count  <= 2'd2;
            cfg_reg.max_kicks   <= 16'd4096;
            cfg_reg.stash_limit <= 3'd4;
            cfg_reg.dummy_fill  <= 8'd0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_HASH_COUNT:  cfg_reg.hash_count  <= pwdata[1:0];
                REG_MAX_KICKS:   cfg_reg.max_kicks   <= pwdata[15:0];
                REG_STASH_LIMIT: cfg_reg.stash_limit <= pwdata[2:0];
                REG_DUMMY_FILL:  cfg_reg.dummy_fill  <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_HASH_COUNT:  prdata = 32'(cfg_reg.hash_count);
            REG_MAX_KICKS:   prdata = 32'(cfg_reg.max_kicks);
            REG_STASH_LIMIT: prdata = 32'(cfg_reg.stash_limit);
            REG_DUMMY_FILL:  prdata = 32'(cfg_reg.dummy_fill);
            default:         prdata = '0;
        endcase
    end

    che_front #(
        .NUM_BINS (NUM_BINS),
        .TAG_BITS (TAG_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .hold      (clearing),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full)
    );

    che_fifo #(
        .WIDTH (CW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    che_back #(
        .NUM_BINS    (NUM_BINS),
        .MAX_HASHES  (MAX_HASHES),
        .STASH_DEPTH (STASH_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .clearing  (clearing),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_data    (q_out),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // hold the result until the transaction completes
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {7'd0, m_res_reg.entry_value, m_res_reg.entry_id,
                       m_res_reg.occupied, m_res_reg.kick_count};

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_tready)
        else $error("item accepted during clearing pass");

    a_read_has_no_kicks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STAT_READ) |-> (m_tdata[15:0] == 16'd0))
        else $error("read result carries a kick count");

    a_insert_not_occupied: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STAT_READ) |-> (m_tdata[96:16] == '0))
        else $error("insert result carries entry fields");

    a_result_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> res_valid)
        else $error("engine dropped a pending result");
`endif

endmodule

// ===== hw/rtl/che_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module che_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/che_fifo.sv =====
// Small command queue between the front end and the insert engine.
`timescale 1ns / 1ps
module che_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/che_front.sv =====
// Front end: accepts items, folds bin addresses into the table range, queues commands.
`timescale 1ns / 1ps
module che_front
    import che_pkg::*;
#(
    parameter int NUM_BINS = 4096,
    parameter int TAG_BITS = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          hold,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,
    input  logic [1:0]    s_tuser,
    output logic          push,
    output logic [2+16+4*$clog2(NUM_BINS)+IN_ADDR_W+TAG_BITS-1:0] push_data,
    input  logic          full
);

    localparam int AW = $clog2(NUM_BINS);

    function automatic int red_steps(int nb);
        int s;
        s = 0;
        for (int k = 0; k < IN_ADDR_W; k++) begin
            if ((longint'(nb) << k) < (longint'(1) << IN_ADDR_W)) begin
                s = k + 1;
            end
        end
        return s;
    endfunction

    function automatic longint red_top(int nb, int steps);
        return (steps > 0) ? (longint'(nb) << (steps - 1)) : longint'(0);
    endfunction

    localparam int RED_STEPS = red_steps(NUM_BINS);
    localparam logic [IN_ADDR_W-1:0] RED_TOP = IN_ADDR_W'(red_top(NUM_BINS, RED_STEPS));
    localparam logic [3:0] LAST_STEP = 4'((RED_STEPS > 0) ? RED_STEPS - 1 : 0);

    fe_state_t state_reg, state_next;

    logic [IN_ADDR_W-1:0] lane_reg [4];
    logic [IN_ADDR_W-1:0] sub_reg;
    logic [3:0]           step_reg;
    logic [1:0]           func_reg;
    logic [15:0]          id_reg;
    logic [IN_ADDR_W-1:0] ri_raw_reg;
    logic [TAG_BITS-1:0]  tag_reg;
    logic                 s_accept;

    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FE_IDLE: begin
                if (s_accept) begin
                    state_next = (RED_STEPS == 0) ? FE_PUSH : FE_REDUCE;
                end
            end
            FE_REDUCE: begin
                if (step_reg == LAST_STEP) begin
                    state_next = FE_PUSH;
                end
            end
            FE_PUSH: begin
                if (!full) begin
                    state_next = FE_IDLE;
                end
            end
            default: state_next = FE_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == FE_IDLE) && !hold;
        push     = (state_reg == FE_PUSH);
    end

    assign push_data = {tag_reg, ri_raw_reg, AW'(lane_reg[3]), AW'(lane_reg[2]),
                        AW'(lane_reg[1]), AW'(lane_reg[0]), id_reg, func_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FE_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // conditional subtract of the table size, largest multiple first
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg    <= s_tuser;
            id_reg      <= s_tdata[15:0];
            lane_reg[0] <= s_tdata[27:16];
            lane_reg[1] <= s_tdata[39:28];
            lane_reg[2] <= s_tdata[51:40];
            lane_reg[3] <= s_tdata[127:116];
            ri_raw_reg  <= s_tdata[127:116];
            tag_reg     <= TAG_BITS'(s_tdata[115:52]);
            sub_reg     <= RED_TOP;
            step_reg    <= '0;
        end else if (state_reg == FE_REDUCE) begin
            for (int i = 0; i < 4; i++) begin
                if (lane_reg[i] >= sub_reg) begin
                    lane_reg[i] <= lane_reg[i] - sub_reg;
                end
            end
            sub_reg  <= sub_reg >> 1;
            step_reg <= step_reg + 1'b1;
        end
    end

endmodule

// ===== hw/rtl/che_back.sv =====
// Back end: probes and evicts in the bin memory, keeps the stash, builds results.
`timescale 1ns / 1ps
module che_back
    import che_pkg::*;
#(
    parameter int NUM_BINS    = 4096,
    parameter int MAX_HASHES  = 3,
    parameter int STASH_DEPTH = 4,
    parameter int TAG_BITS    = 64
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    output logic  clearing,
    input  logic  q_empty,
    output logic  q_pop,
    input  logic [2+16+4*$clog2(NUM_BINS)+IN_ADDR_W+TAG_BITS-1:0] q_data,
    output logic  res_valid,
    input  logic  res_ready,
    output res_t  res
);

    localparam int AW  = $clog2(NUM_BINS);
    localparam int TW  = TAG_BITS;
    localparam int SIW = (STASH_DEPTH > 1) ? $clog2(STASH_DEPTH) : 1;
    localparam int FW  = $clog2(STASH_DEPTH + 1);
    // bin word: {tag, choice, addr2, addr1, addr0, id, valid}
    localparam int BW  = 1 + 16 + 3 * AW + 2 + TW;
    localparam int O_ID  = 1;
    localparam int O_A0  = 17;
    localparam int O_CH  = 17 + 3 * AW;
    localparam int O_TAG = 19 + 3 * AW;
    // command word offsets
    localparam int C_A0  = 18;
    localparam int C_RIB = 18 + 3 * AW;
    localparam int C_RIR = 18 + 4 * AW;
    localparam int C_TAG = 18 + 4 * AW + IN_ADDR_W;

    bk_state_t state_reg, state_next;

    logic [AW-1:0]  clr_reg, clr_next;
    logic [15:0]    cid_reg, cid_next;
    logic [AW-1:0]  ca_reg [3];
    logic [AW-1:0]  ca_next [3];
    logic [TW-1:0]  ctag_reg, ctag_next;
    logic [1:0]     cpos_reg, cpos_next;
    logic [15:0]    iter_reg, iter_next;
    logic [1:0]     pi_reg, pi_next;
    logic [1:0]     ev_reg, ev_next;
    logic [AW-1:0]  rib_reg, rib_next;
    res_t           res_reg, res_next;

    logic [15:0]    stash_reg [STASH_DEPTH];
    logic [FW-1:0]  fill_reg, fill_next;
    logic           stash_we;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [BW-1:0]  ram_wdata, ram_rdata;

    logic           rd_valid;
    logic [15:0]    rd_id;
    logic [1:0]     rd_choice;
    logic [TW-1:0]  rd_tag;
    logic           hash3;
    logic [1:0]     h_last;
    logic [TW-1:0]  dummy_word;
    logic [4:0]     stash_lim;
    logic [IN_ADDR_W-1:0] cmd_rir;

    che_ram #(
        .WIDTH (BW),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    function automatic logic [1:0] next_pos(logic [1:0] x, logic three);
        logic [2:0] y;
        y = {1'b0, x} + 3'd1;
        if (!three) begin
            return {1'b0, y[0]};
        end
        return (y >= 3'd3) ? 2'(y - 3'd3) : y[1:0];
    endfunction

    function automatic logic [BW-1:0] pack_bin(logic [15:0] id, logic [3*AW-1:0] addrs,
                                               logic [1:0] ch, logic [TW-1:0] tag);
        return {tag, ch, addrs, id, 1'b1};
    endfunction

    assign rd_valid  = ram_rdata[0];
    assign rd_id     = ram_rdata[O_ID +: 16];
    assign rd_choice = ram_rdata[O_CH +: 2];
    assign rd_tag    = ram_rdata[O_TAG +: TW];

    assign hash3      = (cfg.hash_count == 2'd3) && (MAX_HASHES >= 3);
    assign h_last     = hash3 ? 2'd2 : 2'd1;
    assign dummy_word = TW'({8{cfg.dummy_fill}});
    assign stash_lim  = ({2'b00, cfg.stash_limit} > 5'(STASH_DEPTH)) ?
                        5'(STASH_DEPTH) : {2'b00, cfg.stash_limit};
    assign cmd_rir    = q_data[C_RIR +: IN_ADDR_W];

    assign clearing  = (state_reg == BK_CLEAR);
    assign res_valid = (state_reg == BK_RESULT);
    assign res       = res_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR: begin
                if (clr_reg == AW'(NUM_BINS - 1)) begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!q_empty) begin
                    case (q_data[1:0])
                        FUNC_INSERT:   state_next = (cfg.max_kicks == '0) ? BK_STASH : BK_PROBE_RD;
                        FUNC_READ_BIN: state_next = BK_BIN_RD;
                        default:       state_next = BK_RESULT;
                    endcase
                end
            end
            BK_PROBE_RD:  state_next = BK_PROBE_CHK;
            BK_PROBE_CHK: begin
                if (!rd_valid) begin
                    state_next = BK_RESULT;
                end else if (pi_reg == h_last) begin
                    state_next = BK_EVICT_RD;
                end else begin
                    state_next = BK_PROBE_RD;
                end
            end
            BK_EVICT_RD:  state_next = BK_EVICT_WR;
            BK_EVICT_WR: begin
                if ((17'(iter_reg) + 17'd1) >= 17'(cfg.max_kicks)) begin
                    state_next = BK_STASH;
                end else begin
                    state_next = BK_PROBE_RD;
                end
            end
            BK_STASH:   state_next = BK_RESULT;
            BK_BIN_RD:  state_next = BK_BIN_CHK;
            BK_BIN_CHK: state_next = BK_RESULT;
            BK_RESULT: begin
                if (res_ready) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        clr_next  = clr_reg;
        cid_next  = cid_reg;
        ca_next   = ca_reg;
        ctag_next = ctag_reg;
        cpos_next = cpos_reg;
        iter_next = iter_reg;
        pi_next   = pi_reg;
        ev_next   = ev_reg;
        rib_next  = rib_reg;
        res_next  = res_reg;
        fill_next = fill_reg;
        stash_we  = 1'b0;
        q_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = ca_reg[pi_reg];
        ram_wdata = pack_bin(cid_reg, {ca_reg[2], ca_reg[1], ca_reg[0]}, pi_reg, ctag_reg);
        ram_raddr = ca_reg[pi_reg];
        case (state_reg)
            BK_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            BK_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    cid_next   = q_data[17:2];
                    ca_next[0] = q_data[C_A0 +: AW];
                    ca_next[1] = q_data[C_A0 + AW +: AW];
                    ca_next[2] = q_data[C_A0 + 2 * AW +: AW];
                    rib_next   = q_data[C_RIB +: AW];
                    ctag_next  = q_data[C_TAG +: TW];
                    cpos_next  = '0;
                    iter_next  = '0;
                    pi_next    = '0;
                    res_next   = '0;
                    res_next.status = STAT_READ;
                    if (q_data[1:0] == FUNC_READ_STASH) begin
                        if ((cmd_rir < IN_ADDR_W'(fill_reg)) &&
                            (cmd_rir < IN_ADDR_W'(STASH_DEPTH))) begin
                            res_next.occupied = 1'b1;
                            res_next.entry_id = stash_reg[cmd_rir[SIW-1:0]];
                        end else begin
                            res_next.entry_value = 64'(dummy_word);
                        end
                    end
                end
            end
            BK_PROBE_CHK: begin
                if (!rd_valid) begin
                    ram_we   = 1'b1;
                    res_next = '0;
                    res_next.status     = STAT_PLACED;
                    res_next.kick_count = iter_reg;
                end else if (pi_reg == h_last) begin
                    // pick the victim: two functions reuse the position, three rotate it
                    cpos_next = hash3 ? next_pos(cpos_reg, 1'b1) : cpos_reg;
                    ev_next   = hash3 ? next_pos(cpos_reg, 1'b1) : {1'b0, cpos_reg[0]};
                end else begin
                    pi_next = pi_reg + 1'b1;
                end
            end
            BK_EVICT_RD: begin
                ram_raddr = ca_reg[ev_reg];
            end
            BK_EVICT_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = ca_reg[ev_reg];
                ram_wdata  = pack_bin(cid_reg, {ca_reg[2], ca_reg[1], ca_reg[0]},
                                      cpos_reg, ctag_reg);
                // carry the displaced occupant onward
                cid_next   = rd_id;
                ca_next[0] = ram_rdata[O_A0 +: AW];
                ca_next[1] = ram_rdata[O_A0 + AW +: AW];
                ca_next[2] = ram_rdata[O_A0 + 2 * AW +: AW];
                ctag_next  = rd_tag;
                cpos_next  = next_pos(rd_choice, hash3);
                iter_next  = iter_reg + 1'b1;
                pi_next    = '0;
            end
            BK_STASH: begin
                res_next = '0;
                res_next.kick_count = iter_reg;
                if (5'(fill_reg) < stash_lim) begin
                    stash_we        = 1'b1;
                    fill_next       = fill_reg + 1'b1;
                    res_next.status = STAT_STASHED;
                end else begin
                    res_next.status = STAT_REJECT;
                end
            end
            BK_BIN_RD: begin
                ram_raddr = rib_reg;
            end
            BK_BIN_CHK: begin
                res_next = '0;
                res_next.status = STAT_READ;
                if (rd_valid) begin
                    res_next.occupied    = 1'b1;
                    res_next.entry_id    = rd_id;
                    res_next.entry_value = 64'(rd_tag ^ TW'(rd_choice));
                end else begin
                    res_next.entry_value = 64'(dummy_word);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_CLEAR;
            clr_reg   <= '0;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        cid_reg  <= cid_next;
        ca_reg   <= ca_next;
        ctag_reg <= ctag_next;
        cpos_reg <= cpos_next;
        iter_reg <= iter_next;
        pi_reg   <= pi_next;
        ev_reg   <= ev_next;
        rib_reg  <= rib_next;
        res_reg  <= res_next;
        if (stash_we) begin
            stash_reg[fill_reg[SIW-1:0]] <= cid_reg;
        end
    end

endmodule
